### sv/oscset_pkg.sv
// ----------------------------------------------------------------------------
// oscset_pkg
// shared widths, range table, configuration codes and item types for the
// oscillator setting calculator
// ----------------------------------------------------------------------------
package oscset_pkg;

    localparam int FREQ_W      = 26;
    localparam int MASTER_W    = 32;
    localparam int EXP_W       = 4;
    localparam int DAC_W       = 10;
    localparam int OFFSET_W    = 8;
    localparam int BASE_W      = 5;
    localparam int CFG_IDX_W   = 3;

    // exponents 0..8 are tried, 9 means no window fit
    localparam int             EXP_STEPS = 9;
    localparam logic [EXP_W-1:0] EXP_NONE = 4'd9;

    localparam int RANGE_COUNT = 13;
    localparam int RANGE_IDX_W = 4;
    localparam logic [RANGE_IDX_W-1:0] RANGE_DEFAULT = 4'd6;
    // distance to a center within a containing range stays at most half a range width
    localparam int DIST_W      = 22;
    localparam int GROUP_SIZE  = 4;
    localparam int GROUP_COUNT = 4;

    localparam int unsigned DAC_STEP_HZ_DEFAULT = 5000;

    localparam logic [FREQ_W-1:0] FREQ_LOW_RESET  = 26'd130000;
    localparam logic [FREQ_W-1:0] FREQ_HIGH_RESET = 26'd66600000;
    localparam logic [FREQ_W-1:0] WIN_LOW_RESET   = 26'd33300000;
    localparam logic [FREQ_W-1:0] WIN_HIGH_RESET  = 26'd66600000;
    localparam logic [BASE_W-1:0] BASE_RESET      = 5'd0;

    localparam logic [MASTER_W-1:0] RANGE_LO [RANGE_COUNT] = '{
        32'd30740000, 32'd33300000, 32'd35860000, 32'd38420000, 32'd40980000,
        32'd43540000, 32'd46100000, 32'd48660000, 32'd51220000, 32'd53780000,
        32'd56340000, 32'd58900000, 32'd61460000
    };
    localparam logic [MASTER_W-1:0] RANGE_HI [RANGE_COUNT] = '{
        32'd35860000, 32'd38420000, 32'd40980000, 32'd43540000, 32'd46100000,
        32'd48660000, 32'd51220000, 32'd53780000, 32'd56340000, 32'd58900000,
        32'd61460000, 32'd64020000, 32'd66580000
    };

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FREQ_LOW    = 3'd0,
        CFG_FREQ_HIGH   = 3'd1,
        CFG_WIN_LOW     = 3'd2,
        CFG_WIN_HIGH    = 3'd3,
        CFG_BASE_OFFSET = 3'd4
    } cfg_index_t;

    typedef struct packed {
        logic [FREQ_W-1:0] freq_low_limit;
        logic [FREQ_W-1:0] freq_high_limit;
        logic [FREQ_W-1:0] osc_window_low;
        logic [FREQ_W-1:0] osc_window_high;
        logic [BASE_W-1:0] base_range_offset;
    } cfg_t;

    typedef struct packed {
        logic                ok;
        logic [EXP_W-1:0]    exp;
        logic [MASTER_W-1:0] master;
    } pre_item_t;

    typedef struct packed {
        logic                   ok;
        logic [EXP_W-1:0]       exp;
        logic [MASTER_W-1:0]    master;
        logic [RANGE_IDX_W-1:0] idx;
    } rng_item_t;

    function automatic logic [MASTER_W-1:0] range_center(input logic [RANGE_IDX_W-1:0] i);
        return RANGE_LO[i] + ((RANGE_HI[i] - RANGE_LO[i]) >> 1);
    endfunction

endpackage

### sv/oscset_prescale.sv
// ----------------------------------------------------------------------------
// oscset_prescale
// limit check and prescale exponent search, one register stage
// ----------------------------------------------------------------------------
module oscset_prescale (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  oscset_pkg::cfg_t                      cfg,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic [oscset_pkg::FREQ_W-1:0]         wanted_freq,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output oscset_pkg::pre_item_t                 out_item
);

    localparam int WIDE_W = oscset_pkg::FREQ_W + oscset_pkg::EXP_STEPS - 1;

    logic [WIDE_W-1:0]                 wide    [oscset_pkg::EXP_STEPS];
    logic [oscset_pkg::MASTER_W-1:0]   shifted [oscset_pkg::EXP_STEPS];
    logic [oscset_pkg::EXP_STEPS-1:0]  fit;
    oscset_pkg::pre_item_t             item_next;
    oscset_pkg::pre_item_t             item_reg;
    logic                              valid_reg;

    always_comb
    begin
        item_next.ok = (wanted_freq >= cfg.freq_low_limit) &&
                       (wanted_freq <= cfg.freq_high_limit);
        for (int e = 0; e < oscset_pkg::EXP_STEPS; e++)
        begin
            wide[e]    = WIDE_W'(wanted_freq) << e;
            shifted[e] = wide[e][oscset_pkg::MASTER_W-1:0];
            fit[e]     = (shifted[e] > oscset_pkg::MASTER_W'(cfg.osc_window_low)) &&
                         (shifted[e] < oscset_pkg::MASTER_W'(cfg.osc_window_high));
        end
        // no fit keeps the largest shift
        item_next.exp    = oscset_pkg::EXP_NONE;
        item_next.master = shifted[oscset_pkg::EXP_STEPS-1];
        for (int e = oscset_pkg::EXP_STEPS - 1; e >= 0; e--)
        begin
            if (fit[e])
            begin
                item_next.exp    = oscset_pkg::EXP_W'(e);
                item_next.master = shifted[e];
            end
        end
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_item  = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            item_reg <= item_next;
        end
    end

endmodule

### sv/oscset_range.sv
// ----------------------------------------------------------------------------
// oscset_range
// picks the containing range with the closest center, else the default range:
// distance stage, group minimum stage, final minimum stage
// ----------------------------------------------------------------------------
module oscset_range (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  oscset_pkg::pre_item_t  in_item,
    output logic                   out_valid,
    input  logic                   out_ready,
    output oscset_pkg::rng_item_t  out_item
);

    localparam int N   = oscset_pkg::RANGE_COUNT;
    localparam int G   = oscset_pkg::GROUP_COUNT;
    localparam int IW  = oscset_pkg::RANGE_IDX_W;
    localparam int DW  = oscset_pkg::DIST_W;

    // stage b: containment and distance per range
    logic                       b_valid_reg;
    oscset_pkg::pre_item_t      b_item_reg;
    logic [N-1:0]               b_hit_next;
    logic [N-1:0]               b_hit_reg;
    logic [DW-1:0]              b_dist_next [N];
    logic [DW-1:0]              b_dist_reg  [N];

    // stage c: best per group
    logic                       c_valid_reg;
    oscset_pkg::pre_item_t      c_item_reg;
    logic [G-1:0]               c_hit_next;
    logic [G-1:0]               c_hit_reg;
    logic [DW-1:0]              c_dist_next [G];
    logic [DW-1:0]              c_dist_reg  [G];
    logic [IW-1:0]              c_idx_next  [G];
    logic [IW-1:0]              c_idx_reg   [G];

    // stage d: overall best
    logic                       d_valid_reg;
    oscset_pkg::rng_item_t      d_item_next;
    oscset_pkg::rng_item_t      d_item_reg;

    logic                       b_ready;
    logic                       c_ready;
    logic                       d_ready;

    logic [oscset_pkg::MASTER_W-1:0] center [N];
    logic [oscset_pkg::MASTER_W-1:0] diff   [N];
    logic                            d_hit;
    logic [DW-1:0]                   d_dist;

    always_comb
    begin
        for (int i = 0; i < N; i++)
        begin
            center[i]     = oscset_pkg::range_center(IW'(i));
            b_hit_next[i] = (in_item.master >= oscset_pkg::RANGE_LO[i]) &&
                            (in_item.master <= oscset_pkg::RANGE_HI[i]);
            diff[i]       = (center[i] >= in_item.master) ? center[i] - in_item.master
                                                          : in_item.master - center[i];
            b_dist_next[i] = diff[i][DW-1:0];
        end
    end

    // lower index wins on equal distance
    always_comb
    begin
        for (int g = 0; g < G; g++)
        begin
            c_hit_next[g]  = 1'b0;
            c_dist_next[g] = '0;
            c_idx_next[g]  = IW'(g * oscset_pkg::GROUP_SIZE);
            for (int k = 0; k < oscset_pkg::GROUP_SIZE; k++)
            begin
                if (g * oscset_pkg::GROUP_SIZE + k < N)
                begin
                    if (b_hit_reg[g * oscset_pkg::GROUP_SIZE + k] &&
                        (!c_hit_next[g] ||
                         b_dist_reg[g * oscset_pkg::GROUP_SIZE + k] < c_dist_next[g]))
                    begin
                        c_hit_next[g]  = 1'b1;
                        c_dist_next[g] = b_dist_reg[g * oscset_pkg::GROUP_SIZE + k];
                        c_idx_next[g]  = IW'(g * oscset_pkg::GROUP_SIZE + k);
                    end
                end
            end
        end
    end

    always_comb
    begin
        d_hit            = 1'b0;
        d_dist           = '0;
        d_item_next.ok     = c_item_reg.ok;
        d_item_next.exp    = c_item_reg.exp;
        d_item_next.master = c_item_reg.master;
        d_item_next.idx    = oscset_pkg::RANGE_DEFAULT;
        for (int g = 0; g < G; g++)
        begin
            if (c_hit_reg[g] && (!d_hit || c_dist_reg[g] < d_dist))
            begin
                d_hit           = 1'b1;
                d_dist          = c_dist_reg[g];
                d_item_next.idx = c_idx_reg[g];
            end
        end
    end

    assign d_ready   = !d_valid_reg || out_ready;
    assign c_ready   = !c_valid_reg || d_ready;
    assign b_ready   = !b_valid_reg || c_ready;
    assign in_ready  = b_ready;
    assign out_valid = d_valid_reg;
    assign out_item  = d_item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
        end
        else
        begin
            if (b_ready)
            begin
                b_valid_reg <= in_valid;
            end
            if (c_ready)
            begin
                c_valid_reg <= b_valid_reg;
            end
            if (d_ready)
            begin
                d_valid_reg <= c_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (b_ready && in_valid)
        begin
            b_item_reg <= in_item;
            b_hit_reg  <= b_hit_next;
            b_dist_reg <= b_dist_next;
        end
        if (c_ready && b_valid_reg)
        begin
            c_item_reg <= b_item_reg;
            c_hit_reg  <= c_hit_next;
            c_dist_reg <= c_dist_next;
            c_idx_reg  <= c_idx_next;
        end
        if (d_ready && c_valid_reg)
        begin
            d_item_reg <= d_item_next;
        end
    end

endmodule

### sv/oscset_dac.sv
// ----------------------------------------------------------------------------
// oscset_dac
// offset code, range difference and constant divide by reciprocal multiply
// split into two partial products; last stage is the output register
// ----------------------------------------------------------------------------
module oscset_dac #(
    parameter int unsigned DAC_STEP_HZ = oscset_pkg::DAC_STEP_HZ_DEFAULT
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic [oscset_pkg::BASE_W-1:0]         base_range_offset,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  oscset_pkg::rng_item_t                 in_item,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic                                  accepted,
    output logic [oscset_pkg::EXP_W-1:0]          prescale_exponent,
    output logic [oscset_pkg::DAC_W-1:0]          dac_code,
    output logic [oscset_pkg::OFFSET_W-1:0]       offset_code
);

    localparam int MW          = oscset_pkg::MASTER_W;
    // exact reciprocal: floor(n * m >> s) == floor(n / d) for every 32-bit n
    localparam int RECIP_SHIFT = MW + $clog2(DAC_STEP_HZ);
    localparam int RECIP_W     = MW + 1;
    localparam int RECIP_SPLIT = 17;
    localparam longint unsigned RECIP_FULL =
        ((64'd1 << RECIP_SHIFT) + 64'(DAC_STEP_HZ) - 64'd1) / 64'(DAC_STEP_HZ);
    localparam logic [RECIP_W-1:0] RECIP    = RECIP_W'(RECIP_FULL);
    localparam logic [RECIP_SPLIT-1:0] RECIP_LO = RECIP[RECIP_SPLIT-1:0];
    localparam logic [RECIP_W-RECIP_SPLIT-1:0] RECIP_HI = RECIP[RECIP_W-1:RECIP_SPLIT];
    localparam int PLO_W  = MW + RECIP_SPLIT;
    localparam int PHI_W  = MW + RECIP_W - RECIP_SPLIT;
    localparam int PROD_W = MW + RECIP_W;

    // stage e: difference and offset
    logic                                   e_valid_reg;
    logic                                   e_ok_reg;
    logic [oscset_pkg::EXP_W-1:0]           e_exp_reg;
    logic [MW-1:0]                          e_diff_next;
    logic [MW-1:0]                          e_diff_reg;
    logic [oscset_pkg::OFFSET_W-1:0]        e_offset_next;
    logic [oscset_pkg::OFFSET_W-1:0]        e_offset_reg;

    // stage f: partial products
    logic                                   f_valid_reg;
    logic                                   f_ok_reg;
    logic [oscset_pkg::EXP_W-1:0]           f_exp_reg;
    logic [oscset_pkg::OFFSET_W-1:0]        f_offset_reg;
    logic [PLO_W-1:0]                       f_plo_next;
    logic [PLO_W-1:0]                       f_plo_reg;
    logic [PHI_W-1:0]                       f_phi_next;
    logic [PHI_W-1:0]                       f_phi_reg;

    // stage g: output register
    logic                                   g_valid_reg;
    logic [PROD_W-1:0]                      g_prod;
    logic                                   g_ok_next;
    logic                                   g_ok_reg;
    logic [oscset_pkg::EXP_W-1:0]           g_exp_next;
    logic [oscset_pkg::EXP_W-1:0]           g_exp_reg;
    logic [oscset_pkg::DAC_W-1:0]           g_dac_next;
    logic [oscset_pkg::DAC_W-1:0]           g_dac_reg;
    logic [oscset_pkg::OFFSET_W-1:0]        g_offset_next;
    logic [oscset_pkg::OFFSET_W-1:0]        g_offset_reg;

    logic e_ready;
    logic f_ready;
    logic g_ready;

    always_comb
    begin
        // master below the range minimum wraps
        e_diff_next   = in_item.master - oscset_pkg::RANGE_LO[in_item.idx];
        e_offset_next = oscset_pkg::OFFSET_W'(base_range_offset) +
                        oscset_pkg::OFFSET_W'(in_item.idx) -
                        oscset_pkg::OFFSET_W'(oscset_pkg::RANGE_DEFAULT);
    end

    always_comb
    begin
        f_plo_next = PLO_W'(e_diff_reg) * PLO_W'(RECIP_LO);
        f_phi_next = PHI_W'(e_diff_reg) * PHI_W'(RECIP_HI);
    end

    // rejected items give all-zero fields
    always_comb
    begin
        g_prod        = (PROD_W'(f_phi_reg) << RECIP_SPLIT) + PROD_W'(f_plo_reg);
        g_ok_next     = f_ok_reg;
        g_exp_next    = f_ok_reg ? f_exp_reg : '0;
        g_dac_next    = f_ok_reg ? g_prod[RECIP_SHIFT +: oscset_pkg::DAC_W] : '0;
        g_offset_next = f_ok_reg ? f_offset_reg : '0;
    end

    assign g_ready  = !g_valid_reg || out_ready;
    assign f_ready  = !f_valid_reg || g_ready;
    assign e_ready  = !e_valid_reg || f_ready;
    assign in_ready = e_ready;

    assign out_valid         = g_valid_reg;
    assign accepted          = g_ok_reg;
    assign prescale_exponent = g_exp_reg;
    assign dac_code          = g_dac_reg;
    assign offset_code       = g_offset_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e_valid_reg <= 1'b0;
            f_valid_reg <= 1'b0;
            g_valid_reg <= 1'b0;
        end
        else
        begin
            if (e_ready)
            begin
                e_valid_reg <= in_valid;
            end
            if (f_ready)
            begin
                f_valid_reg <= e_valid_reg;
            end
            if (g_ready)
            begin
                g_valid_reg <= f_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (e_ready && in_valid)
        begin
            e_ok_reg     <= in_item.ok;
            e_exp_reg    <= in_item.exp;
            e_diff_reg   <= e_diff_next;
            e_offset_reg <= e_offset_next;
        end
        if (f_ready && e_valid_reg)
        begin
            f_ok_reg     <= e_ok_reg;
            f_exp_reg    <= e_exp_reg;
            f_offset_reg <= e_offset_reg;
            f_plo_reg    <= f_plo_next;
            f_phi_reg    <= f_phi_next;
        end
        if (g_ready && f_valid_reg)
        begin
            g_ok_reg     <= g_ok_next;
            g_exp_reg    <= g_exp_next;
            g_dac_reg    <= g_dac_next;
            g_offset_reg <= g_offset_next;
        end
    end

endmodule

### sv/oscillator_setting_calculator_core.sv
// ----------------------------------------------------------------------------
// oscillator_setting_calculator_core
// stages: 7 register stages, the first loaded at the accept edge
//   (1 prescale stage, 3 range select stages, 3 dac stages ending in the
//   output register)
// throughput: one item per cycle unless stalled; every stage holds its item
//   under backpressure and takes a new one as soon as its successor frees up
// reset: configuration registers return to their defaults, pipeline empties
// ----------------------------------------------------------------------------
module oscillator_setting_calculator_core #(
    parameter int unsigned DAC_STEP_HZ = oscset_pkg::DAC_STEP_HZ_DEFAULT
) (
    input  logic                                  clk,
    input  logic                                  rst_n,

    // configuration write channel
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [oscset_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [oscset_pkg::FREQ_W-1:0]         cfg_data,

    // request items
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic [oscset_pkg::FREQ_W-1:0]         wanted_freq,

    // result items
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic                                  accepted,
    output logic [oscset_pkg::EXP_W-1:0]          prescale_exponent,
    output logic [oscset_pkg::DAC_W-1:0]          dac_code,
    output logic [oscset_pkg::OFFSET_W-1:0]       offset_code
);

    // configuration registers, to be written only while no item is in flight,
    // so every stage reads them live; the block itself does not enforce this
    oscset_pkg::cfg_t       cfg_reg;

    // prescale -> range select
    logic                   pre_valid;
    logic                   pre_ready;
    oscset_pkg::pre_item_t  pre_item;

    // range select -> dac
    logic                   rng_valid;
    logic                   rng_ready;
    oscset_pkg::rng_item_t  rng_item;

    // writes are always accepted
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.freq_low_limit    <= oscset_pkg::FREQ_LOW_RESET;
            cfg_reg.freq_high_limit   <= oscset_pkg::FREQ_HIGH_RESET;
            cfg_reg.osc_window_low    <= oscset_pkg::WIN_LOW_RESET;
            cfg_reg.osc_window_high   <= oscset_pkg::WIN_HIGH_RESET;
            cfg_reg.base_range_offset <= oscset_pkg::BASE_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            // indexes past the register list are dropped
            unique case (oscset_pkg::cfg_index_t'(cfg_index))
                oscset_pkg::CFG_FREQ_LOW:    cfg_reg.freq_low_limit    <= cfg_data;
                oscset_pkg::CFG_FREQ_HIGH:   cfg_reg.freq_high_limit   <= cfg_data;
                oscset_pkg::CFG_WIN_LOW:     cfg_reg.osc_window_low    <= cfg_data;
                oscset_pkg::CFG_WIN_HIGH:    cfg_reg.osc_window_high   <= cfg_data;
                oscset_pkg::CFG_BASE_OFFSET:
                begin
                    cfg_reg.base_range_offset <= cfg_data[oscset_pkg::BASE_W-1:0];
                end
                default:
                begin
                    cfg_reg <= cfg_reg;
                end
            endcase
        end
    end

    // limit check, first exponent that lands inside the window
    oscset_prescale u_prescale (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .wanted_freq (wanted_freq),
        .out_valid   (pre_valid),
        .out_ready   (pre_ready),
        .out_item    (pre_item)
    );

    // closest-center containing range, default index when none contains it
    oscset_range u_range (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (pre_valid),
        .in_ready  (pre_ready),
        .in_item   (pre_item),
        .out_valid (rng_valid),
        .out_ready (rng_ready),
        .out_item  (rng_item)
    );

    // offset code and fine-tune code, result register
    oscset_dac #(
        .DAC_STEP_HZ (DAC_STEP_HZ)
    ) u_dac (
        .clk               (clk),
        .rst_n             (rst_n),
        .base_range_offset (cfg_reg.base_range_offset),
        .in_valid          (rng_valid),
        .in_ready          (rng_ready),
        .in_item           (rng_item),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .accepted          (accepted),
        .prescale_exponent (prescale_exponent),
        .dac_code          (dac_code),
        .offset_code       (offset_code)
    );

endmodule
